/* design/lpr_pkg.sv */
// shared types, constants and the mask bit count for the route lookup
`default_nettype none

package lpr_pkg;

  localparam int TableDepthDef = 32;
  localparam int PortBitsDef   = 4;

  localparam int InDataW  = 144;
  localparam int OutDataW = 48;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } lpr_cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } lpr_state_e;

  // entry update broadcast to every cell
  typedef struct packed {
    logic        en;
    logic [4:0]  index;
    logic        valid;
    logic [31:0] dest;
    logic [31:0] mask;
    logic [5:0]  len;
    logic [3:0]  port;
    logic [31:0] gateway;
  } lpr_wr_t;

  // lookup request and its best match so far, passed from cell to cell
  typedef struct packed {
    logic        active;
    logic [31:0] addr;
    logic        found;
    logic [4:0]  idx;
    logic [5:0]  len;
    logic [3:0]  port;
    logic [31:0] gateway;
  } lpr_tok_t;

  // adder tree over the 32 mask bits
  function automatic logic [5:0] ones32(input logic [31:0] w);
    logic [1:0] s1 [16];
    logic [2:0] s2 [8];
    logic [3:0] s3 [4];
    logic [4:0] s4 [2];
    for (int i = 0; i < 16; i++) begin
      s1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    end
    return {1'b0, s4[0]} + {1'b0, s4[1]};
  endfunction

endpackage

`default_nettype wire

/* design/lpr_cell.sv */
// one route table entry plus the stage that checks a passing lookup against it
`default_nettype none

module lpr_cell #(
  parameter int CellIdx  = 0,
  parameter int PortBits = lpr_pkg::PortBitsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             advance_i,
  input  wire lpr_pkg::lpr_wr_t wr_i,
  input  wire lpr_pkg::lpr_tok_t tok_i,
  output lpr_pkg::lpr_tok_t     tok_o
);

  logic                valid_q;
  logic [31:0]         dest_q;
  logic [31:0]         mask_q;
  logic [5:0]          len_q;
  logic [PortBits-1:0] port_q;
  logic [31:0]         gw_q;

  logic                sel;
  logic                match;
  lpr_pkg::lpr_tok_t   tok_d;
  lpr_pkg::lpr_tok_t   tok_q;
  logic                act_q;

  assign sel = wr_i.en && (32'(wr_i.index) == CellIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sel) begin
      valid_q <= wr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel) begin
      dest_q <= wr_i.dest;
      mask_q <= wr_i.mask;
      len_q  <= wr_i.len;
      port_q <= PortBits'(wr_i.port);
      gw_q   <= wr_i.gateway;
    end
  end

  // strictly longer wins, so on a tie the earlier cell keeps the match
  assign match = tok_i.active && valid_q && (((tok_i.addr ^ dest_q) & mask_q) == 32'd0)
                 && (!tok_i.found || (len_q > tok_i.len));

  always_comb begin
    tok_d = tok_i;
    if (match) begin
      tok_d.found   = 1'b1;
      tok_d.idx     = 5'(CellIdx);
      tok_d.len     = len_q;
      tok_d.port    = 4'(port_q);
      tok_d.gateway = gw_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (advance_i) begin
      act_q <= tok_i.active;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      tok_q <= tok_d;
    end
  end

  always_comb begin
    tok_o        = tok_q;
    tok_o.active = act_q;
  end

endmodule

`default_nettype wire

/* design/longest_prefix_route_lookup_top.sv */
// Longest-prefix route lookup: a row of entry cells that a lookup walks one cell per cycle.
//
// Input stream (s_axis_*): tuser is the command, write entry or look up address.
// A write updates one slot and gives no result; a slot number at or beyond the table
// depth is dropped. A lookup enters the first cell and moves one cell per cycle unless
// held in the last cell, each cell keeping the longer match (the earlier slot on a tie),
// and the last cell's result is registered onto m_axis_*.
// One lookup is in the row at a time: tready is low while it walks and in the cycle that
// hands its result over; writes go at one per cycle while no lookup is in the row.
// Output stream (m_axis_*): one result per lookup, all zero fields when nothing matched.
// The result register frees the input side, so the next request is taken while a
// result waits. If the receiver stalls with a result held, the next lookup stops in
// the last cell until the register drains.
// Reset clears every valid mark and the control state; stored entry fields are kept
// only through writes and are never read before one.
`default_nettype none

module longest_prefix_route_lookup_top #(
  parameter int TABLE_DEPTH = lpr_pkg::TableDepthDef,
  parameter int PORT_BITS   = lpr_pkg::PortBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // entry_index[4:0] entry_valid[5] entry_dest[37:6] entry_mask[69:38]
  // entry_port[73:70] entry_gateway[105:74] lookup_address[137:106] zeros[143:138]
  input  wire logic [lpr_pkg::InDataW-1:0]  s_axis_tdata,
  // command[0]
  input  wire logic                         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // hit[0] match_index[5:1] out_port[9:6] next_hop[41:10] prefix_length[47:42]
  output logic [lpr_pkg::OutDataW-1:0]      m_axis_tdata
);

  lpr_pkg::lpr_state_e state_q;
  lpr_pkg::lpr_state_e state_d;

  logic              in_acc;
  logic              is_lookup;
  logic              advance;
  logic              load_out;
  lpr_pkg::lpr_wr_t  wr;
  lpr_pkg::lpr_tok_t inject;
  lpr_pkg::lpr_tok_t tok [TABLE_DEPTH];
  lpr_pkg::lpr_tok_t last;
  logic [TABLE_DEPTH-1:0] tok_act;

  logic        m_valid_q;
  logic        hit_q;
  logic [4:0]  idx_q;
  logic [3:0]  port_q;
  logic [31:0] hop_q;
  logic [5:0]  len_q;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign is_lookup = (s_axis_tuser == lpr_pkg::CMD_LOOKUP);

  // entry update, bit count of the mask taken once here for all cells
  always_comb begin
    wr.en      = in_acc && !is_lookup;
    wr.index   = s_axis_tdata[4:0];
    wr.valid   = s_axis_tdata[5];
    wr.dest    = s_axis_tdata[37:6];
    wr.mask    = s_axis_tdata[69:38];
    wr.len     = lpr_pkg::ones32(s_axis_tdata[69:38]);
    wr.port    = s_axis_tdata[73:70];
    wr.gateway = s_axis_tdata[105:74];
  end

  always_comb begin
    inject.active  = in_acc && is_lookup;
    inject.addr    = s_axis_tdata[137:106];
    inject.found   = 1'b0;
    inject.idx     = 5'd0;
    inject.len     = 6'd0;
    inject.port    = 4'd0;
    inject.gateway = 32'd0;
  end

  assign last     = tok[TABLE_DEPTH-1];
  assign load_out = last.active && (!m_valid_q || m_axis_tready);
  assign advance  = !last.active || load_out;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    lpr_pkg::lpr_tok_t cell_in;
    if (k == 0) begin : g_head
      assign cell_in = inject;
    end else begin : g_body
      assign cell_in = tok[k-1];
    end
    lpr_cell #(
      .CellIdx  (k),
      .PortBits (PORT_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .wr_i      (wr),
      .tok_i     (cell_in),
      .tok_o     (tok[k])
    );
    assign tok_act[k] = tok[k].active;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lpr_pkg::ST_IDLE: begin
        if (in_acc && is_lookup) begin
          state_d = lpr_pkg::ST_SCAN;
        end
      end
      lpr_pkg::ST_SCAN: begin
        if (load_out) begin
          state_d = lpr_pkg::ST_IDLE;
        end
      end
      default: state_d = lpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_q)
      lpr_pkg::ST_IDLE: s_axis_tready = 1'b1;
      lpr_pkg::ST_SCAN: s_axis_tready = 1'b0;
      default:          s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      hit_q  <= last.found;
      idx_q  <= last.idx;
      port_q <= last.port;
      hop_q  <= last.gateway;
      len_q  <= last.len;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {len_q, hop_q, port_q, idx_q, hit_q};

`ifndef SYNTHESIS
  a_one_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_act) <= 1)
    else $error("more than one lookup in the cell row");

  a_exit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last.active |-> (state_q == lpr_pkg::ST_SCAN))
    else $error("lookup leaves the row outside a scan");

  a_lookup_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_lookup) |=> (state_q == lpr_pkg::ST_SCAN) && !s_axis_tready)
    else $error("accepted lookup did not start a scan");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !hit_q) |-> (idx_q == 5'd0) && (port_q == 4'd0) && (hop_q == 32'd0)
                              && (len_q == 6'd0))
    else $error("miss result carries nonzero fields");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// testbench for the longest-prefix route lookup: random table writes and lookups checked on the fly
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = lpr_pkg::TableDepthDef;
  localparam int NUM_RANDOM     = 1300;
  localparam int HOLDOFF_CYCLES = 150;
  localparam int TAIL_CYCLES    = 3 * DEPTH + 20;
  localparam int IDLE_LIMIT     = 4000;

  typedef struct packed {
    logic              drain;
    logic [2:0]        gap;
    lpr_pkg::lpr_cmd_e cmd;
    logic [4:0]        slot;
    logic              on;
    logic [31:0]       net;
    logic [31:0]       msk;
    logic [3:0]        port;
    logic [31:0]       gw;
    logic [31:0]       addr;
  } route_req_t;

  typedef struct packed {
    logic        hit;
    logic [4:0]  slot;
    logic [3:0]  port;
    logic [31:0] gw;
    logic [5:0]  plen;
  } route_res_t;

  logic                         clk_i    = 1'b0;
  logic                         rst_ni   = 1'b0;
  logic                         s_tvalid = 1'b0;
  logic [lpr_pkg::InDataW-1:0]  s_tdata  = '0;
  logic                         s_tuser  = 1'b0;
  logic                         m_tready = 1'b0;
  logic                         s_axis_tready;
  logic                         m_axis_tvalid;
  logic [lpr_pkg::OutDataW-1:0] m_axis_tdata;

  route_req_t req_queue[$];
  route_res_t expected_routes[$];
  int         outstanding = 0;
  int         gap_done    = 0;
  int         err_cnt     = 0;
  int         n_lookup    = 0;
  int         n_write     = 0;
  int         n_hit       = 0;
  int         n_holdoff   = 0;
  int         idle_cnt    = 0;
  int         rx_wait     = 0;
  int         rx_count    = 0;
  bit         calm        = 1'b0;

  // predictor's copy of the route table
  logic        tbl_on  [DEPTH];
  logic [31:0] tbl_net [DEPTH];
  logic [31:0] tbl_msk [DEPTH];
  logic [3:0]  tbl_port[DEPTH];
  logic [31:0] tbl_gw  [DEPTH];

  // generator's view of the installed networks, used to aim lookups
  logic [31:0] gen_net[DEPTH];
  logic [31:0] gen_msk[DEPTH];

  longest_prefix_route_lookup_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [5:0] net_bits(input logic [31:0] m);
    logic [5:0] n;
    n = '0;
    for (int b = 0; b < 32; b++) begin
      n = n + 6'(m[b]);
    end
    return n;
  endfunction

  function automatic logic [31:0] prefix_mask(input int len);
    return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  function automatic route_res_t predict_route(input logic [31:0] addr);
    route_res_t r;
    logic [5:0] len;
    r = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (tbl_on[i] && ((addr & tbl_msk[i]) == (tbl_net[i] & tbl_msk[i]))) begin
        len = net_bits(tbl_msk[i]);
        // strictly longer only, so the lowest slot keeps a tie
        if (!r.hit || len > r.plen) begin
          r.hit  = 1'b1;
          r.slot = i[4:0];
          r.port = tbl_port[i];
          r.gw   = tbl_gw[i];
          r.plen = len;
        end
      end
    end
    return r;
  endfunction

  task automatic add_write(input int slot, input bit on, input logic [31:0] net,
                           input logic [31:0] msk, input logic [3:0] port,
                           input logic [31:0] gw);
    route_req_t r;
    r      = '0;
    r.gap  = calm ? 3'd0 : 3'($urandom_range(0, 5));
    r.cmd  = lpr_pkg::CMD_WRITE;
    r.slot = slot[4:0];
    r.on   = on;
    r.net  = net;
    r.msk  = msk;
    r.port = port;
    r.gw   = gw;
    r.addr = $urandom;
    if (on) begin
      gen_net[slot] = net;
      gen_msk[slot] = msk;
    end
    req_queue.push_back(r);
  endtask

  task automatic add_lookup(input logic [31:0] addr);
    route_req_t r;
    r      = '0;
    r.gap  = calm ? 3'd0 : 3'($urandom_range(0, 5));
    r.cmd  = lpr_pkg::CMD_LOOKUP;
    r.slot = 5'($urandom);
    r.on   = 1'($urandom);
    r.net  = $urandom;
    r.msk  = $urandom;
    r.port = 4'($urandom);
    r.gw   = $urandom;
    r.addr = addr;
    req_queue.push_back(r);
  endtask

  task automatic add_drain();
    route_req_t r;
    r       = '0;
    r.drain = 1'b1;
    req_queue.push_back(r);
  endtask

  // sender: one request per handshake, gap cycles taken before each
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    route_req_t nxt;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
      gap_done <= 0;
    end else if (!s_tvalid || s_axis_tready) begin
      if (req_queue.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (req_queue[0].drain) begin
        s_tvalid <= 1'b0;
        // hold until every lookup already sent has returned
        if (!s_tvalid && outstanding == 0) begin
          nxt = req_queue.pop_front();
        end
      end else if (gap_done < req_queue[0].gap) begin
        s_tvalid <= 1'b0;
        gap_done <= gap_done + 1;
      end else begin
        nxt      = req_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= nxt.cmd;
        s_tdata  <= {6'b0, nxt.addr, nxt.gw, nxt.port, nxt.msk, nxt.net, nxt.on, nxt.slot};
        gap_done <= 0;
      end
    end
  end

  // receiver: random stall per result except in no-stall stretches, plus two long holdoffs
  always @(posedge clk_i or negedge rst_ni) begin : recv_proc
    int w;
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      rx_wait   <= 0;
      rx_count  <= 0;
      n_holdoff <= 0;
    end else if (m_axis_tvalid && m_tready) begin
      if (rx_count == 50 || rx_count == 700) begin
        w = HOLDOFF_CYCLES;
        n_holdoff <= n_holdoff + 1;
      end else if ((rx_count / 64) % 3 == 1) begin
        w = 0;
      end else begin
        w = $urandom_range(0, 5);
      end
      rx_count <= rx_count + 1;
      rx_wait  <= w;
      m_tready <= (w == 0);
    end else if (rx_wait > 0) begin
      rx_wait  <= rx_wait - 1;
      m_tready <= (rx_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // predict on accepted requests, check accepted results
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    route_res_t want;
    route_res_t got;
    int         delta;
    logic [4:0] slot;
    if (!rst_ni) begin
      outstanding <= 0;
      for (int i = 0; i < DEPTH; i++) begin
        tbl_on[i] = 1'b0;
      end
    end else begin
      delta = 0;
      if (m_axis_tvalid && m_tready) begin
        got.hit  = m_axis_tdata[0];
        got.slot = m_axis_tdata[5:1];
        got.port = m_axis_tdata[9:6];
        got.gw   = m_axis_tdata[41:10];
        got.plen = m_axis_tdata[47:42];
        if (expected_routes.size() == 0) begin
          if (err_cnt < 10) begin
            $display("%0t: result with no lookup pending: hit=%0d slot=%0d port=%0d gw=%h len=%0d",
                     $realtime, got.hit, got.slot, got.port, got.gw, got.plen);
          end
          err_cnt++;
        end else begin
          want = expected_routes.pop_front();
          delta--;
          if (want.hit) n_hit++;
          if (got.hit !== want.hit || got.slot !== want.slot || got.port !== want.port ||
              got.gw !== want.gw || got.plen !== want.plen) begin
            if (err_cnt < 10) begin
              $display("%0t: route mismatch exp hit=%0d slot=%0d port=%0d gw=%h len=%0d",
                       $realtime, want.hit, want.slot, want.port, want.gw, want.plen);
              $display("%0t:                got hit=%0d slot=%0d port=%0d gw=%h len=%0d",
                       $realtime, got.hit, got.slot, got.port, got.gw, got.plen);
            end
            err_cnt++;
          end
        end
      end
      if (s_tvalid && s_axis_tready) begin
        if (lpr_pkg::lpr_cmd_e'(s_tuser) == lpr_pkg::CMD_LOOKUP) begin
          expected_routes.push_back(predict_route(s_tdata[137:106]));
          delta++;
          n_lookup++;
        end else begin
          slot = s_tdata[4:0];
          if (int'(slot) < DEPTH) begin
            tbl_on[slot]   = s_tdata[5];
            tbl_net[slot]  = s_tdata[37:6];
            tbl_msk[slot]  = s_tdata[69:38];
            tbl_port[slot] = s_tdata[73:70];
            tbl_gw[slot]   = s_tdata[105:74];
          end
          n_write++;
        end
      end
      outstanding <= outstanding + delta;
    end
  end

  always @(posedge clk_i) begin : watchdog_proc
    if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d results pending",
               IDLE_LIMIT, outstanding);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : main_proc
    logic [31:0] net;
    logic [31:0] msk;
    int          pick;
    int          s;
    for (int i = 0; i < DEPTH; i++) begin
      gen_net[i] = '0;
      gen_msk[i] = '0;
    end

    // directed: empty table, default route, host route, ties, removal
    calm = 1'b1;
    add_lookup(32'h0000_0000);
    add_write(0, 1'b1, 32'hFFFF_FFFF, 32'h0, 4'hF, 32'hFFFF_FFFF);
    add_lookup(32'hFFFF_FFFF);
    add_lookup(32'h0000_0000);
    add_write(31, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0, 32'h0);
    add_lookup(32'hFFFF_FFFF);
    add_lookup(32'hFFFF_FFFE);
    // non-contiguous mask ties a /16 at a lower slot
    add_write(5, 1'b1, 32'hA0B0_C0D0, 32'hF0F0_F0F0, 4'h7, 32'h1234_5678);
    add_write(3, 1'b1, 32'hA0B0_0000, 32'hFFFF_0000, 4'h9, 32'h8765_4321);
    add_lookup(32'hA0B0_C0D0);
    add_lookup(32'hA5B5_C5D5);
    add_write(3, 1'b0, 32'hA0B0_0000, 32'hFFFF_0000, 4'h9, 32'h8765_4321);
    add_lookup(32'hA0B0_C0D0);
    // equal /24 entries: lower slot wins
    add_write(20, 1'b1, 32'h0A00_0100, 32'hFFFF_FF00, 4'h2, 32'h0A00_0001);
    add_write(10, 1'b1, 32'h0A00_0100, 32'hFFFF_FF00, 4'h4, 32'h0A00_0002);
    add_lookup(32'h0A00_0155);
    add_write(10, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF);
    add_lookup(32'h0A00_01AA);
    // drop the default route: unmatched addresses miss again
    add_write(0, 1'b0, 32'h0, 32'h0, 4'h0, 32'h0);
    add_lookup(32'h0102_0304);
    add_write(17, 1'b1, 32'h0, 32'h0, 4'h5, 32'hC0A8_0001);
    add_lookup(32'h0102_0304);
    add_lookup(32'hFFFF_FFFF);
    add_drain();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      calm = ((n / 100) % 3 == 2);
      if (n == 500 || n == 1000) add_drain();
      if ($urandom_range(0, 99) < 22) begin
        s    = $urandom_range(0, DEPTH - 1);
        pick = $urandom_range(0, 9);
        if (pick < 6) msk = prefix_mask($urandom_range(0, 32));
        else if (pick < 8) msk = $urandom;
        else msk = pick[0] ? 32'hFFFF_FFFF : 32'h0;
        // half the networks nest inside an existing one
        if ($urandom_range(0, 1) == 1) begin
          net = gen_net[$urandom_range(0, DEPTH - 1)] ^ ($urandom >> $urandom_range(4, 31));
        end else begin
          net = $urandom;
        end
        add_write(s, $urandom_range(0, 99) < 85, net, msk, 4'($urandom), $urandom);
      end else if ($urandom_range(0, 3) != 0) begin
        s = $urandom_range(0, DEPTH - 1);
        add_lookup((gen_net[s] & gen_msk[s]) | ($urandom & ~gen_msk[s]));
      end else begin
        add_lookup($urandom);
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (req_queue.size() != 0 || s_tvalid || outstanding != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("covered %0d lookups (%0d hits, %0d misses) and %0d table writes",
             n_lookup, n_hit, n_lookup - n_hit, n_write);
    $display("with %0d long result holdoffs, %0d errors, %0d results left unreturned",
             n_holdoff, err_cnt, expected_routes.size());
    if (err_cnt == 0 && expected_routes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
